@@ hw/rtl/drrip_stream_dead_block_replacement_core_assert.svh @@
// assertion macros shared by the replacement core rtl
// expects clk and rst_n in the scope of every use
`ifndef DRRIP_STREAM_DEAD_BLOCK_REPLACEMENT_CORE_ASSERT_SVH
`define DRRIP_STREAM_DEAD_BLOCK_REPLACEMENT_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define DRRIP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DRRIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/drrip_pkg.sv @@
// shared types, constants and helpers of the replacement core
// no dependencies
package drrip_pkg;

    localparam int DEF_NUM_SETS    = 2048;
    localparam int DEF_NUM_WAYS    = 16;
    localparam int DEF_LEADER_SETS = 64;
    localparam int DEF_SEL_BITS    = 10;

    localparam int ADDR_W     = 64;
    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PERIOD_W   = 32;
    localparam int RAND_W     = 16;

    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_NEAR = 2'd2;
    localparam logic [1:0] RRPV_HIT  = 2'd0;
    localparam logic [1:0] DEAD_MAX  = 2'd3;
    localparam logic [1:0] DEAD_FILL = 2'd1;
    localparam logic [1:0] STREAM_ON = 2'd2;
    localparam logic [1:0] STREAM_TOP = 2'd3;

    localparam logic [PERIOD_W-1:0] DEF_DECAY = 32'd100000;
    localparam logic [RAND_W-1:0]   DEF_SEED  = 16'd44257;
    localparam logic [RAND_W-1:0]   LFSR_POLY = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd1;

    typedef enum logic [2:0] {
        ROW_PASS,
        ROW_FIND_DEAD,
        ROW_AGE,
        ROW_FIND_TOP,
        ROW_SET,
        ROW_DECAY
    } row_op_t;

    typedef struct packed {
        row_op_t    op;
        logic [1:0] rrpv;
        logic [1:0] dead;
    } row_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_FIND_DEAD,
        ST_AGE,
        ST_FIND_TOP,
        ST_PROMOTE,
        ST_STREAM,
        ST_INSERT,
        ST_MOD,
        ST_RESULT,
        ST_SWEEP
    } state_t;

    // one step of the right-shifting galois lfsr
    function automatic logic [RAND_W-1:0] lfsr_step(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] t;
        t = s >> 1;
        if (s[0])
        begin
            t = t ^ LFSR_POLY;
        end
        return t;
    endfunction

endpackage

@@ hw/rtl/drrip_in_if.sv @@
// access channel carrying one query or update beat
// depends on drrip_pkg
interface drrip_in_if;
    import drrip_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [ADDR_W-1:0]   address;
    logic                hit;

    modport source (output valid, mode, set_index, way_index, address, hit, input ready);
    modport sink (input valid, mode, set_index, way_index, address, hit, output ready);
endinterface

@@ hw/rtl/drrip_out_if.sv @@
// result channel carrying the victim way beat
// depends on drrip_pkg
interface drrip_out_if;
    import drrip_pkg::*;

    logic                valid;
    logic                ready;
    logic [WAY_IN_W-1:0] victim_way;

    modport source (output valid, victim_way, input ready);
    modport sink (input valid, victim_way, output ready);
endinterface

@@ hw/rtl/drrip_cfg_if.sv @@
// register write channel
// depends on drrip_pkg
interface drrip_cfg_if;
    import drrip_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/drrip_row_unit.sv @@
// shared row unit: search, ageing, single way write and decay over one set row
// depends on drrip_pkg
module drrip_row_unit #(
    parameter int NUM_WAYS = drrip_pkg::DEF_NUM_WAYS
) (
    input  drrip_pkg::row_ctrl_t           ctrl,
    input  logic [$clog2(NUM_WAYS)-1:0]    way,
    input  logic [4*NUM_WAYS-1:0]          row,
    output logic [4*NUM_WAYS-1:0]          row_out,
    output logic                           found,
    output logic [$clog2(NUM_WAYS)-1:0]    found_way
);
    import drrip_pkg::*;

    localparam int WAY_W = $clog2(NUM_WAYS);

    logic [NUM_WAYS-1:0] match;
    logic                any3;
    logic                any2;
    logic                any1;
    logic [1:0]          top;
    logic [1:0]          add;

    // per-way match vector and rrpv presence flags
    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            case (ctrl.op)
                ROW_FIND_DEAD: match[w] = (row[4*w +: 2] == RRPV_MAX) && (row[4*w+2 +: 2] == 2'd0);
                ROW_FIND_TOP:  match[w] = (row[4*w +: 2] == RRPV_MAX);
                default:       match[w] = 1'b0;
            endcase
            any3 = any3 | (row[4*w +: 2] == 2'd3);
            any2 = any2 | (row[4*w +: 2] == 2'd2);
            any1 = any1 | (row[4*w +: 2] == 2'd1);
        end
        if (any3)
        begin
            top = 2'd3;
        end
        else if (any2)
        begin
            top = 2'd2;
        end
        else if (any1)
        begin
            top = 2'd1;
        end
        else
        begin
            top = 2'd0;
        end
        add = RRPV_MAX - top;
    end

    // first matching way, lowest index wins
    always_comb
    begin
        found     = |match;
        found_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                found_way = WAY_W'(w);
            end
        end
    end

    // row rewrite
    always_comb
    begin
        row_out = row;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            case (ctrl.op)
                ROW_AGE:
                begin
                    row_out[4*w +: 2] = row[4*w +: 2] + add;
                end
                ROW_SET:
                begin
                    if (way == WAY_W'(w))
                    begin
                        row_out[4*w +: 2]   = ctrl.rrpv;
                        row_out[4*w+2 +: 2] = ctrl.dead;
                    end
                end
                ROW_DECAY:
                begin
                    if (row[4*w+2 +: 2] != 2'd0)
                    begin
                        row_out[4*w+2 +: 2] = row[4*w+2 +: 2] - 2'd1;
                    end
                end
                default:
                begin
                    row_out[4*w +: 4] = row[4*w +: 4];
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/drrip_mod_unit.sv @@
// restoring remainder unit, one quotient bit per cycle
// depends on drrip_pkg
module drrip_mod_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [drrip_pkg::PERIOD_W-1:0]  dividend,
    input  logic [drrip_pkg::PERIOD_W-1:0]  divisor,
    output logic                            done,
    output logic [drrip_pkg::PERIOD_W-1:0]  remainder
);
    import drrip_pkg::*;

    localparam int STEP_W = $clog2(PERIOD_W + 1);

    logic [PERIOD_W-1:0] rem_reg,   rem_next;
    logic [PERIOD_W-1:0] num_reg,   num_next;
    logic [PERIOD_W-1:0] den_reg,   den_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [PERIOD_W:0]   trial;

    // one shift and conditional subtract per cycle
    always_comb
    begin
        rem_next   = rem_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        steps_next = steps_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, num_reg[PERIOD_W-1]};
        if (start)
        begin
            rem_next   = '0;
            num_next   = dividend;
            den_next   = divisor;
            steps_next = STEP_W'(PERIOD_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = PERIOD_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = PERIOD_W'(trial);
            end
            num_next   = num_reg << 1;
            steps_next = steps_reg - STEP_W'(1);
            if (steps_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            num_reg   <= '0;
            den_reg   <= '0;
            steps_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            steps_reg <= steps_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/drrip_stream_dead_block_replacement_core.sv @@
// top level: sequencer, set row and stream memories, selector and lfsr
// depends on drrip_pkg, the channel interfaces, drrip_row_unit, drrip_mod_unit
//
// Replacement state for a set-associative cache. A beat is taken only when the
// sequencer is idle. A victim query loads the set row over the single set-row
// read port (one registered read) and searches for a dead way with rrpv 3; when
// none exists the set is aged and searched again. A hit update writes the way;
// a fill writes the stream entry, then the way. The shared row unit does one
// search, ageing or write step per cycle. After reset a clearing pass writes
// every set row and stream entry, one set a cycle, so no beat is accepted until
// it ends. Every sweep interval (register 0, in updates) a fill triggers a
// dead-counter sweep over all sets after its result, with no beat accepted
// until it ends. The first fill after the sweep interval is written waits for
// the remainder unit. Register writes are taken at any time.
module drrip_stream_dead_block_replacement_core #(
    parameter int NUM_SETS    = drrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS    = drrip_pkg::DEF_NUM_WAYS,
    parameter int LEADER_SETS = drrip_pkg::DEF_LEADER_SETS,
    parameter int SEL_BITS    = drrip_pkg::DEF_SEL_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    drrip_in_if.sink      in_ch,
    drrip_out_if.source   out_ch,
    drrip_cfg_if.sink     cfg
);
    import drrip_pkg::*;

    `include "drrip_stream_dead_block_replacement_core_assert.svh"

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int CNT_W  = SET_W + 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int ROW_W  = 4 * NUM_WAYS;
    localparam int STRM_W = 2 + 2 * ADDR_W;
    localparam int MAP_W  = 17;

    localparam logic [SET_W-1:0]    LEAD_LO  = SET_W'(LEADER_SETS);
    localparam logic [SET_W-1:0]    LEAD_HI  = SET_W'(NUM_SETS - LEADER_SETS);
    localparam logic [CNT_W-1:0]    SETS_CNT = CNT_W'(NUM_SETS);
    localparam logic [SEL_BITS-1:0] SEL_MID  = SEL_BITS'(1) << (SEL_BITS - 1);
    localparam logic [ROW_W-1:0]    ROW_INIT = {NUM_WAYS{2'd0, RRPV_MAX}};

    // set index folded into range, at most eight subtractions for an 11 bit index
    function automatic logic [SET_W-1:0] map_set(input logic [SET_IN_W-1:0] s);
        logic [MAP_W-1:0] v;
        v = MAP_W'(s);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= MAP_W'(NUM_SETS))
            begin
                v = v - MAP_W'(NUM_SETS);
            end
        end
        return SET_W'(v);
    endfunction

    // memories
    logic [ROW_W-1:0]  row_mem  [NUM_SETS];
    logic [STRM_W-1:0] strm_mem [NUM_SETS];
    logic [ROW_W-1:0]  row_rdata_reg;
    logic [STRM_W-1:0] strm_rdata_reg;
    logic              row_we;
    logic [SET_W-1:0]  row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [SET_W-1:0]  row_raddr;
    logic              strm_we;
    logic [SET_W-1:0]  strm_waddr;
    logic [STRM_W-1:0] strm_wdata;
    logic [SET_W-1:0]  strm_raddr;

    // control and payload registers
    state_t                state_reg,      state_next;
    logic [CNT_W-1:0]      idx_reg,        idx_next;
    logic                  wr_pend_reg,    wr_pend_next;
    logic [SET_W-1:0]      sweep_addr_reg, sweep_addr_next;
    logic                  mode_reg,       mode_next;
    logic [SET_W-1:0]      set_reg,        set_next;
    logic [WAY_W-1:0]      way_reg,        way_next;
    logic                  way_ok_reg,     way_ok_next;
    logic [ADDR_W-1:0]     addr_reg,       addr_next;
    logic                  hit_reg,        hit_next;
    logic [ROW_W-1:0]      row_reg,        row_next;
    logic [1:0]            scnt_reg,       scnt_next;
    logic [ADDR_W-1:0]     slast_reg,      slast_next;
    logic [ADDR_W-1:0]     sdelta_reg,     sdelta_next;
    logic [1:0]            ins_reg,        ins_next;
    logic [WAY_IN_W-1:0]   victim_reg,     victim_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [WAY_IN_W-1:0]   out_way_reg,    out_way_next;
    logic [SEL_BITS-1:0]   psel_reg,       psel_next;
    logic [PERIOD_W-1:0]   ucount_reg,     ucount_next;
    logic [PERIOD_W-1:0]   rem_reg,        rem_next;
    logic                  stale_reg,      stale_next;
    logic                  sweep_pend_reg, sweep_pend_next;
    logic [PERIOD_W-1:0]   decay_reg,      decay_next;
    logic [RAND_W-1:0]     rand_reg,       rand_next;

    // shared units
    row_ctrl_t             rctrl;
    logic [ROW_W-1:0]      row_in;
    logic [ROW_W-1:0]      row_res;
    logic                  row_found;
    logic [WAY_W-1:0]      row_found_way;
    logic                  mod_start;
    logic                  mod_done;
    logic [PERIOD_W-1:0]   mod_rem;

    // datapath helpers
    logic                  in_fire;
    logic                  out_load;
    logic                  srrip_lead;
    logic                  brrip_lead;
    logic [ADDR_W-1:0]     delta;
    logic                  stride_match;
    logic [1:0]            scnt_new;
    logic [RAND_W-1:0]     rand_step;
    logic [1:0]            ins_pick;
    logic [PERIOD_W-1:0]   ucount_inc;
    logic [PERIOD_W-1:0]   rem_inc;
    logic [PERIOD_W-1:0]   rem_adv;

    drrip_row_unit #(
        .NUM_WAYS (NUM_WAYS)
    ) u_row (
        .ctrl      (rctrl),
        .way       (way_reg),
        .row       (row_in),
        .row_out   (row_res),
        .found     (row_found),
        .found_way (row_found_way)
    );

    // remainder of the count after this fill's increment
    drrip_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (ucount_inc),
        .divisor   (decay_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_load = !out_valid_reg || out_ch.ready;
    assign row_in   = (state_reg == ST_SWEEP) ? row_rdata_reg : row_reg;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.victim_way = out_way_reg;
    assign cfg.ready         = 1'b1;

    // leader classification, stream detector step, insertion depth and sweep counter advance
    always_comb
    begin
        srrip_lead   = (set_reg < LEAD_LO);
        brrip_lead   = !srrip_lead && (set_reg >= LEAD_HI);
        delta        = (slast_reg == '0) ? '0 : (addr_reg - slast_reg);
        stride_match = (slast_reg != '0) && (delta == sdelta_reg) && (delta != '0);
        if (stride_match)
        begin
            scnt_new = (scnt_reg == STREAM_TOP) ? scnt_reg : scnt_reg + 2'd1;
        end
        else
        begin
            scnt_new = (scnt_reg == 2'd0) ? scnt_reg : scnt_reg - 2'd1;
        end
        rand_step = lfsr_step(rand_reg);
        ucount_inc = ucount_reg + PERIOD_W'(1);
        rem_inc    = rem_reg + PERIOD_W'(1);
        if (ucount_inc == '0 || rem_inc == decay_reg)
        begin
            rem_adv = '0;
        end
        else
        begin
            rem_adv = rem_inc;
        end
        if (srrip_lead)
        begin
            ins_pick = RRPV_NEAR;
        end
        else if (brrip_lead || psel_reg < SEL_MID)
        begin
            ins_pick = (rand_step[4:0] == 5'd0) ? RRPV_NEAR : RRPV_MAX;
        end
        else
        begin
            ins_pick = RRPV_NEAR;
        end
        if (scnt_new >= STREAM_ON)
        begin
            ins_pick = RRPV_MAX;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == SETS_CNT - CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!mode_reg)
                begin
                    state_next = ST_FIND_DEAD;
                end
                else if (!way_ok_reg)
                begin
                    state_next = ST_RESULT;
                end
                else if (hit_reg)
                begin
                    state_next = ST_PROMOTE;
                end
                else
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_FIND_DEAD: state_next = row_found ? ST_RESULT : ST_AGE;
            ST_AGE:       state_next = ST_FIND_TOP;
            ST_FIND_TOP:  state_next = ST_RESULT;
            ST_PROMOTE:   state_next = ST_RESULT;
            ST_STREAM:    state_next = ST_INSERT;
            ST_INSERT:
            begin
                if (decay_reg != '0 && stale_reg)
                begin
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = sweep_pend_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (idx_reg == SETS_CNT && wr_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        idx_next        = idx_reg;
        wr_pend_next    = wr_pend_reg;
        sweep_addr_next = sweep_addr_reg;
        mode_next       = mode_reg;
        set_next        = set_reg;
        way_next        = way_reg;
        way_ok_next     = way_ok_reg;
        addr_next       = addr_reg;
        hit_next        = hit_reg;
        row_next        = row_reg;
        scnt_next       = scnt_reg;
        slast_next      = slast_reg;
        sdelta_next     = sdelta_reg;
        ins_next        = ins_reg;
        victim_next     = victim_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_way_next    = out_way_reg;
        psel_next       = psel_reg;
        ucount_next     = ucount_reg;
        rem_next        = rem_reg;
        stale_next      = stale_reg;
        sweep_pend_next = sweep_pend_reg;
        decay_next      = decay_reg;
        rand_next       = rand_reg;
        rctrl           = '{op: ROW_PASS, rrpv: 2'd0, dead: 2'd0};
        mod_start       = 1'b0;
        row_we          = 1'b0;
        row_waddr       = set_reg;
        row_wdata       = row_res;
        row_raddr       = set_reg;
        strm_we         = 1'b0;
        strm_waddr      = set_reg;
        strm_wdata      = {scnt_new, addr_reg, delta};
        strm_raddr      = set_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                row_we     = 1'b1;
                row_waddr  = idx_reg[SET_W-1:0];
                row_wdata  = ROW_INIT;
                strm_we    = 1'b1;
                strm_waddr = idx_reg[SET_W-1:0];
                strm_wdata = '0;
                idx_next   = (idx_reg == SETS_CNT - CNT_W'(1)) ? '0 : idx_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                row_raddr  = map_set(in_ch.set_index);
                strm_raddr = map_set(in_ch.set_index);
                if (in_fire)
                begin
                    mode_next   = in_ch.mode;
                    set_next    = map_set(in_ch.set_index);
                    way_next    = WAY_W'(in_ch.way_index);
                    way_ok_next = (32'(in_ch.way_index) < 32'(NUM_WAYS));
                    addr_next   = in_ch.address;
                    hit_next    = in_ch.hit;
                end
            end
            ST_LOAD:
            begin
                row_next    = row_rdata_reg;
                scnt_next   = strm_rdata_reg[STRM_W-1 -: 2];
                slast_next  = strm_rdata_reg[2*ADDR_W-1 -: ADDR_W];
                sdelta_next = strm_rdata_reg[ADDR_W-1:0];
                victim_next = '0;
            end
            ST_FIND_DEAD:
            begin
                rctrl.op    = ROW_FIND_DEAD;
                victim_next = WAY_IN_W'(row_found_way);
            end
            ST_AGE:
            begin
                rctrl.op = ROW_AGE;
                row_next = row_res;
                row_we   = 1'b1;
            end
            ST_FIND_TOP:
            begin
                rctrl.op    = ROW_FIND_TOP;
                victim_next = row_found ? WAY_IN_W'(row_found_way) : '0;
            end
            ST_PROMOTE:
            begin
                rctrl       = '{op: ROW_SET, rrpv: RRPV_HIT, dead: DEAD_MAX};
                row_we      = 1'b1;
                ucount_next = ucount_inc;
                if (!stale_reg)
                begin
                    rem_next = rem_adv;
                end
            end
            ST_STREAM:
            begin
                strm_we  = 1'b1;
                ins_next = ins_pick;
                if (!srrip_lead && (brrip_lead || psel_reg < SEL_MID))
                begin
                    rand_next = rand_step;
                end
            end
            ST_INSERT:
            begin
                rctrl       = '{op: ROW_SET, rrpv: ins_reg, dead: DEAD_FILL};
                row_we      = 1'b1;
                ucount_next = ucount_inc;
                if (srrip_lead && psel_reg != '0)
                begin
                    psel_next = psel_reg - SEL_BITS'(1);
                end
                else if (brrip_lead && psel_reg != '1)
                begin
                    psel_next = psel_reg + SEL_BITS'(1);
                end
                if (!stale_reg)
                begin
                    rem_next        = rem_adv;
                    sweep_pend_next = (decay_reg != '0) && (rem_adv == '0);
                end
                else if (decay_reg != '0)
                begin
                    mod_start = 1'b1;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    rem_next        = mod_rem;
                    stale_next      = 1'b0;
                    sweep_pend_next = (mod_rem == '0);
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_way_next    = victim_reg;
                    sweep_pend_next = 1'b0;
                    idx_next        = '0;
                    wr_pend_next    = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                rctrl.op  = ROW_DECAY;
                row_raddr = (idx_reg < SETS_CNT) ? idx_reg[SET_W-1:0] : '0;
                row_waddr = sweep_addr_reg;
                row_we    = wr_pend_reg;
                if (idx_reg < SETS_CNT)
                begin
                    wr_pend_next    = 1'b1;
                    sweep_addr_next = idx_reg[SET_W-1:0];
                    idx_next        = idx_reg + CNT_W'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    idx_next     = '0;
                end
            end
            default:
            begin
                rctrl.op = ROW_PASS;
            end
        endcase

        // register writes
        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_DECAY)
            begin
                decay_next = cfg.data;
                stale_next = 1'b1;
            end
            else if (cfg.index == CFG_SEED)
            begin
                rand_next = (cfg.data[RAND_W-1:0] == '0) ? RAND_W'(1) : cfg.data[RAND_W-1:0];
            end
        end
    end

    // set row and stream memories
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rdata_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (strm_we)
        begin
            strm_mem[strm_waddr] <= strm_wdata;
        end
        strm_rdata_reg <= strm_mem[strm_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            psel_reg       <= SEL_MID;
            ucount_reg     <= '0;
            rem_reg        <= '0;
            stale_reg      <= 1'b0;
            sweep_pend_reg <= 1'b0;
            decay_reg      <= DEF_DECAY;
            rand_reg       <= DEF_SEED;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            wr_pend_reg    <= wr_pend_next;
            out_valid_reg  <= out_valid_next;
            psel_reg       <= psel_next;
            ucount_reg     <= ucount_next;
            rem_reg        <= rem_next;
            stale_reg      <= stale_next;
            sweep_pend_reg <= sweep_pend_next;
            decay_reg      <= decay_next;
            rand_reg       <= rand_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sweep_addr_reg <= sweep_addr_next;
        mode_reg       <= mode_next;
        set_reg        <= set_next;
        way_reg        <= way_next;
        way_ok_reg     <= way_ok_next;
        addr_reg       <= addr_next;
        hit_reg        <= hit_next;
        row_reg        <= row_next;
        scnt_reg       <= scnt_next;
        slast_reg      <= slast_next;
        sdelta_reg     <= sdelta_next;
        ins_reg        <= ins_next;
        victim_reg     <= victim_next;
        out_way_reg    <= out_way_next;
    end

    // checks
    `DRRIP_ASSERT_ALWAYS(a_lfsr_nonzero, rand_reg != '0, "lfsr reached the all-zero state")
    `DRRIP_ASSERT_IMP(a_mod_divisor_held, state_reg == ST_MOD, decay_reg != '0 && stale_reg, "remainder unit running without a valid period")
    `DRRIP_ASSERT_IMP(a_query_victim_range, state_reg == ST_RESULT && !mode_reg, 32'(victim_reg) < 32'(NUM_WAYS) || NUM_WAYS > 16, "query victim outside the ways")
    `DRRIP_ASSERT_IMP(a_sweep_after_fill, state_reg == ST_SWEEP && idx_reg == '0, $past(state_reg) == ST_RESULT && $past(mode_reg) && !$past(hit_reg), "decay sweep not started by a fill")

endmodule

@@ dv/tb_drrip_stream_dead_block_replacement_core.sv @@
// self-checking testbench for the drrip replacement core: directed rows, then random beats
// checked against an in-bench model of the rrpv, dead-block, stream and selector state
// depends on drrip_pkg, the three channel interfaces and the core rtl
module tb_drrip_stream_dead_block_replacement_core;
    import drrip_pkg::*;

    localparam int NSETS   = DEF_NUM_SETS;
    localparam int NWAYS   = DEF_NUM_WAYS;
    localparam int NLEAD   = DEF_LEADER_SETS;
    localparam int SELW    = DEF_SEL_BITS;
    localparam int SETTLE  = 2300;
    localparam int LIMIT   = 1000000;

    typedef struct {
        logic                mode;
        logic [SET_IN_W-1:0] set_idx;
        logic [WAY_IN_W-1:0] way;
        logic [ADDR_W-1:0]   addr;
        logic                hit_f;
        bit                  known;
        logic [3:0]          want;
    } beat_t;

    logic clk;
    logic rst_n;

    drrip_in_if  in_ch ();
    drrip_out_if out_ch ();
    drrip_cfg_if cfg ();

    drrip_stream_dead_block_replacement_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // model state
    logic [1:0]  rrpv_mem [NSETS][NWAYS];
    logic [1:0]  dead_mem [NSETS][NWAYS];
    logic [1:0]  strm_cnt [NSETS];
    logic [63:0] miss_addr [NSETS];
    logic [63:0] miss_delta [NSETS];
    logic [SELW-1:0] psel;
    logic [31:0] access_cnt;
    logic [15:0] lfsr;
    logic [31:0] decay_len;

    logic [3:0] victim_q [$];
    beat_t      typed_q [$];
    beat_t      dir_rows [$];

    bit fail_seen;
    bit calm;
    bit hold_req;
    int cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // galois lfsr step, true on the one-in-32 near insertion
    function automatic bit brrip_pick_near();
        logic [15:0] s;
        s = lfsr >> 1;
        if (lfsr[0])
        begin
            s = s ^ 16'hB400;
        end
        lfsr = s;
        return s[4:0] == 5'd0;
    endfunction

    function automatic logic [3:0] choose_victim(int s);
        logic [1:0] top;
        top = 2'd0;
        for (int w = 0; w < NWAYS; w++)
        begin
            if (rrpv_mem[s][w] == RRPV_MAX && dead_mem[s][w] == 2'd0)
            begin
                return w[3:0];
            end
        end
        for (int w = 0; w < NWAYS; w++)
        begin
            if (rrpv_mem[s][w] > top)
            begin
                top = rrpv_mem[s][w];
            end
        end
        for (int w = 0; w < NWAYS; w++)
        begin
            rrpv_mem[s][w] = rrpv_mem[s][w] + (RRPV_MAX - top);
        end
        for (int w = 0; w < NWAYS; w++)
        begin
            if (rrpv_mem[s][w] == RRPV_MAX)
            begin
                return w[3:0];
            end
        end
        return 4'd0;
    endfunction

    function automatic void train_fill(int s, int w, logic [63:0] a);
        bit          srrip_lead;
        bit          brrip_lead;
        logic [1:0]  ins;
        logic [63:0] delta;
        srrip_lead = s < NLEAD;
        brrip_lead = !srrip_lead && s >= NSETS - NLEAD;
        ins = RRPV_NEAR;
        delta = (miss_addr[s] == 64'd0) ? 64'd0 : a - miss_addr[s];
        // stream confidence
        if (miss_addr[s] != 64'd0 && delta == miss_delta[s] && delta != 64'd0)
        begin
            if (strm_cnt[s] != 2'd3)
            begin
                strm_cnt[s]++;
            end
        end
        else if (strm_cnt[s] != 2'd0)
        begin
            strm_cnt[s]--;
        end
        miss_delta[s] = delta;
        miss_addr[s] = a;
        // insertion depth
        if (!srrip_lead && (brrip_lead || psel < (1 << (SELW - 1))))
        begin
            ins = brrip_pick_near() ? RRPV_NEAR : RRPV_MAX;
        end
        if (strm_cnt[s] >= 2'd2)
        begin
            ins = RRPV_MAX;
        end
        rrpv_mem[s][w] = ins;
        dead_mem[s][w] = DEAD_FILL;
        // set dueling
        if (srrip_lead && psel != 0)
        begin
            psel--;
        end
        else if (brrip_lead && psel != {SELW{1'b1}})
        begin
            psel++;
        end
        // periodic dead-counter sweep
        if (decay_len != 32'd0 && (access_cnt % decay_len) == 32'd0)
        begin
            for (int i = 0; i < NSETS; i++)
            begin
                for (int j = 0; j < NWAYS; j++)
                begin
                    if (dead_mem[i][j] != 2'd0)
                    begin
                        dead_mem[i][j]--;
                    end
                end
            end
        end
    endfunction

    function automatic logic [3:0] predict_access(beat_t b);
        int s;
        int w;
        s = int'(b.set_idx) % NSETS;
        w = int'(b.way);
        if (!b.mode)
        begin
            return choose_victim(s);
        end
        if (w < NWAYS)
        begin
            access_cnt++;
            if (b.hit_f)
            begin
                dead_mem[s][w] = DEAD_MAX;
                rrpv_mem[s][w] = RRPV_HIT;
            end
            else
            begin
                train_fill(s, w, b.addr);
            end
        end
        return 4'd0;
    endfunction

    function automatic beat_t row(logic m, int s, int w, logic [63:0] a, logic h,
                                  bit k, int v);
        beat_t b;
        b.mode = m;
        b.set_idx = s[SET_IN_W-1:0];
        b.way = w[WAY_IN_W-1:0];
        b.addr = a;
        b.hit_f = h;
        b.known = k;
        b.want = v[3:0];
        return b;
    endfunction

    // random beat; lean 0 mixes sets, 1 favours srrip leaders, 2 brrip leaders
    function automatic beat_t random_beat(int lean);
        beat_t       b;
        int          r;
        int          s;
        logic [63:0] stride;
        r = $urandom_range(0, 99);
        if (lean == 1)
        begin
            r = (r < 60) ? 0 : r;
        end
        else if (lean == 2)
        begin
            r = (r < 60) ? 20 : r;
        end
        if (r < 15)
        begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NLEAD - 1) : $urandom_range(0, 3);
        end
        else if (r < 30)
        begin
            s = NSETS - 1 - $urandom_range(0, 3);
        end
        else if (r < 88)
        begin
            s = 700 + $urandom_range(0, 7);
        end
        else
        begin
            s = $urandom_range(0, NSETS - 1);
        end
        b.set_idx = s[SET_IN_W-1:0];
        b.mode = $urandom_range(0, 99) >= 45;
        b.way = WAY_IN_W'($urandom_range(0, NWAYS - 1));
        b.hit_f = $urandom_range(0, 2) == 0;
        b.known = 1'b0;
        b.want = 4'd0;
        case ($urandom_range(0, 3))
            0: stride = 64'd64;
            1: stride = 64'd128;
            2: stride = -64'd64;
            default: stride = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 9) < 6 && miss_addr[s] != 64'd0)
        begin
            b.addr = miss_addr[s] + stride;
        end
        else
        begin
            b.addr = {$urandom, $urandom};
        end
        return b;
    endfunction

    // one access beat with an optional idle burst before it; starts and ends on a falling edge
    task automatic send_beat(beat_t b);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        typed_q.push_back(b);
        in_ch.mode      <= b.mode;
        in_ch.set_index <= b.set_idx;
        in_ch.way_index <= b.way;
        in_ch.address   <= b.addr;
        in_ch.hit       <= b.hit_f;
        in_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // wait for every victim beat, then for any sweep the last fill set off
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (victim_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // one register beat, then the channel is left quiet before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.index <= idx;
        cfg.data  <= value;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        if (idx == CFG_DECAY)
        begin
            decay_len = value;
        end
        else
        begin
            lfsr = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
        end
        @(negedge clk);
    endtask

    task automatic random_run(int count, int lean, int calm_tail);
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count - calm_tail);
            if (i == count / 3 && lean == 0)
            begin
                hold_req = 1'b1;
            end
            send_beat(random_beat(lean));
        end
        calm = 1'b0;
    endtask

    // accepted beats feed the model; result beats are checked against it
    always @(posedge clk)
    begin
        beat_t      b;
        logic [3:0] got;
        logic [3:0] exp_way;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.victim_way;
            if (victim_q.size() == 0)
            begin
                $display("%0t unexpected victim beat: expected none actual %0d", $time, got);
                fail_seen = 1'b1;
            end
            else
            begin
                exp_way = victim_q.pop_front();
                if (got !== exp_way)
                begin
                    $display("%0t victim_way mismatch: expected %0d actual %0d",
                             $time, exp_way, got);
                    fail_seen = 1'b1;
                end
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            b = typed_q.pop_front();
            exp_way = predict_access(b);
            victim_q.push_back(b.known ? b.want : exp_way);
        end
    end

    // result side: random stall bursts and a long hold in each lean-0 run
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (399) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.set_index = '0;
        in_ch.way_index = '0;
        in_ch.address = '0;
        in_ch.hit = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_DECAY;
        cfg.data = '0;
        fail_seen = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        cycles = 0;
        for (int i = 0; i < NSETS; i++)
        begin
            for (int j = 0; j < NWAYS; j++)
            begin
                rrpv_mem[i][j] = RRPV_MAX;
                dead_mem[i][j] = 2'd0;
            end
            strm_cnt[i] = 2'd0;
            miss_addr[i] = 64'd0;
            miss_delta[i] = 64'd0;
        end
        psel = SELW'(1) << (SELW - 1);
        access_cnt = 32'd0;
        decay_len = DEF_DECAY;
        lfsr = DEF_SEED;

        // directed rows: fresh sets, promotion, extremes, leader edges, a stride stream
        dir_rows.push_back(row(0, 0, 0, 64'd0, 0, 1, 0));
        dir_rows.push_back(row(0, 2047, 15, '1, 1, 1, 0));
        dir_rows.push_back(row(1, 0, 0, 64'd0, 1, 1, 0));
        dir_rows.push_back(row(0, 0, 0, 64'd0, 0, 1, 1));
        dir_rows.push_back(row(1, 2047, 15, '1, 0, 1, 0));
        dir_rows.push_back(row(1, 100, 3, 64'h1000, 0, 1, 0));
        dir_rows.push_back(row(1, 100, 4, 64'h1040, 0, 1, 0));
        dir_rows.push_back(row(1, 100, 5, 64'h1080, 0, 1, 0));
        dir_rows.push_back(row(1, 100, 6, 64'h10C0, 0, 1, 0));
        dir_rows.push_back(row(0, 100, 0, 64'd0, 0, 0, 0));
        dir_rows.push_back(row(1, 5, 0, 64'd0, 0, 0, 0));
        dir_rows.push_back(row(1, 700, 15, 64'd0, 1, 0, 0));
        dir_rows.push_back(row(0, 700, 9, 64'h5555_AAAA_5555_AAAA, 1, 0, 0));
        dir_rows.push_back(row(0, 1500, 0, 64'd0, 0, 0, 0));
        dir_rows.push_back(row(1, 1984, 7, 64'h8000_0000_0000_0000, 0, 0, 0));
        dir_rows.push_back(row(1, 63, 8, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0));
        dir_rows.push_back(row(1, 64, 9, 64'h40, 0, 0, 0));
        dir_rows.push_back(row(0, 1984, 0, 64'd0, 0, 0, 0));
        dir_rows.push_back(row(1, 100, 3, 64'h1100, 1, 0, 0));
        dir_rows.push_back(row(0, 100, 0, 64'd0, 0, 0, 0));
        dir_rows.push_back(row(0, 1983, 0, 64'd0, 0, 0, 0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i]);
        end
        settle();

        // sweep on every fill, zero seed
        write_reg(CFG_SEED, 32'd0);
        write_reg(CFG_DECAY, 32'd1);
        random_run(20, 0, 0);
        settle();

        // no decay, drive the selector down with srrip leader fills
        write_reg(CFG_DECAY, 32'd0);
        write_reg(CFG_SEED, 32'd65535);
        random_run(320, 1, 0);
        settle();

        // longest period, brrip-heavy mix
        write_reg(CFG_DECAY, 32'hFFFF_FFFF);
        write_reg(CFG_SEED, $urandom_range(1, 65535));
        random_run(320, 2, 0);
        settle();

        // short period with the long result hold and a calm tail
        write_reg(CFG_DECAY, 32'd37);
        write_reg(CFG_SEED, $urandom_range(0, 65535));
        random_run(940, 0, 200);
        settle();

        if (!fail_seen && victim_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            if (victim_q.size() != 0)
            begin
                $display("%0t victim beats missing: expected %0d more actual 0",
                         $time, victim_q.size());
            end
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ drrip_stream_dead_block_replacement_core.f @@
+incdir+hw/rtl
hw/rtl/drrip_pkg.sv
hw/rtl/drrip_in_if.sv
hw/rtl/drrip_out_if.sv
hw/rtl/drrip_cfg_if.sv
hw/rtl/drrip_row_unit.sv
hw/rtl/drrip_mod_unit.sv
hw/rtl/drrip_stream_dead_block_replacement_core.sv
dv/tb_drrip_stream_dead_block_replacement_core.sv
